@@ src/spm_pkg.sv @@
package spm_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int MAX_SLOTS    = 512;
	localparam int HEADER_BYTES = 16;
	localparam int SLOT_BYTES   = 4;
	localparam int PREFIX_BYTES = 4;
	localparam int RSVD_BYTES   = 4;

	localparam int PAGE_AW = $clog2(PAGE_BYTES);
	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int CNT_W   = SLOT_AW + 1;
	localparam int OFF_W   = PAGE_AW + 1;
	localparam int LEN_W   = 12;
	localparam int IDX_W   = 12;
	localparam int QDEPTH  = 2;

	localparam logic [OFF_W-1:0] TOP_INIT = OFF_W'(PAGE_BYTES - RSVD_BYTES);

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_INSERT = 3'd1,
		OP_UPDATE = 3'd2,
		OP_WBYTE  = 3'd3,
		OP_RBYTE  = 3'd4,
		OP_DELETE = 3'd5,
		OP_NEXT   = 3'd6,
		OP_NOP    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_BEYOND  = 3'd2,
		ST_DELETED = 3'd3,
		ST_TOOBIG  = 3'd4,
		ST_NONE    = 3'd5,
		ST_RANGE   = 3'd6
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [SLOT_AW-1:0] slot;
		logic [LEN_W-1:0] size;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic             live;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
	} slot_ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_BRD,
		S_SCAN,
		S_PFX
	} bstate_t;

endpackage

@@ src/spm_ram.sv @@
module spm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ src/spm_front.sv @@
module spm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 mode,
	input  logic [spm_pkg::SLOT_AW-1:0] slot,
	input  logic [spm_pkg::LEN_W-1:0]  size,
	input  logic [spm_pkg::IDX_W-1:0]  byte_index,
	input  logic [7:0]                 data_byte,
	output logic                       q_valid,
	output spm_pkg::item_t             q_item,
	input  logic                       q_pop
);

	spm_pkg::item_t entry_q [spm_pkg::QDEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	spm_pkg::item_t cls;
	logic           push;

	// classify the mode code into an operation
	always_comb begin
		cls.slot       = slot;
		cls.size       = size;
		cls.byte_index = byte_index;
		cls.data_byte  = data_byte;
		unique case (mode)
			3'd0:    cls.op = spm_pkg::OP_INIT;
			3'd1:    cls.op = spm_pkg::OP_INSERT;
			3'd2:    cls.op = spm_pkg::OP_UPDATE;
			3'd3:    cls.op = spm_pkg::OP_WBYTE;
			3'd4:    cls.op = spm_pkg::OP_RBYTE;
			3'd5:    cls.op = spm_pkg::OP_DELETE;
			3'd6:    cls.op = spm_pkg::OP_NEXT;
			default: cls.op = spm_pkg::OP_NOP;
		endcase
	end

	assign in_ready = (cnt_q != 2'(spm_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(spm_pkg::QDEPTH)) else $error("queue count overflow");
	ap_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(spm_pkg::QDEPTH) && !q_pop) |=> cnt_q == 2'(spm_pkg::QDEPTH))
		else $error("full queue lost an entry");

endmodule

@@ src/spm_back.sv @@
module spm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  spm_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [spm_pkg::SLOT_AW-1:0] slot_number,
	output logic [spm_pkg::LEN_W-1:0]   length,
	output logic [7:0]                  read_data,
	output logic [spm_pkg::OFF_W-1:0]   free_bytes
);

	spm_pkg::bstate_t state_q, state_d;
	spm_pkg::item_t   it_q, it_d;

	logic [spm_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [spm_pkg::OFF_W-1:0]   top_q, top_d;
	logic [spm_pkg::OFF_W-1:0]   toff_q, toff_d;
	logic [spm_pkg::SLOT_AW-1:0] tslot_q, tslot_d;
	logic                        tv_q, tv_d;
	logic [spm_pkg::SLOT_AW-1:0] scan_q, scan_d;
	logic [spm_pkg::OFF_W-1:0]   paddr_q, paddr_d;
	logic [spm_pkg::LEN_W-1:0]   pval_q, pval_d;
	logic [1:0]                  k_q, k_d;

	logic                        ov_q, ov_d;
	spm_pkg::status_t            st_q, st_d;
	logic [spm_pkg::SLOT_AW-1:0] sn_q, sn_d;
	logic [spm_pkg::LEN_W-1:0]   len_q, len_d;
	logic [7:0]                  rd_q, rd_d;

	logic                        s_we;
	logic [spm_pkg::SLOT_AW-1:0] s_addr;
	spm_pkg::slot_ent_t          s_wd, s_rd;
	logic                        p_we;
	logic [spm_pkg::PAGE_AW-1:0] p_addr;
	logic [7:0]                  p_wd, p_rd;

	logic [spm_pkg::OFF_W-1:0]   dir_end, gap, need, newtop, baddr, taddr;
	logic [7:0]                  pbyte;

	assign dir_end = spm_pkg::OFF_W'(spm_pkg::HEADER_BYTES)
		+ spm_pkg::OFF_W'(cnt_q) * spm_pkg::OFF_W'(spm_pkg::SLOT_BYTES);
	assign gap     = (top_q > dir_end) ? top_q - dir_end : '0;
	assign need    = spm_pkg::OFF_W'(q_item.size)
		+ spm_pkg::OFF_W'(spm_pkg::PREFIX_BYTES + spm_pkg::SLOT_BYTES);
	assign newtop  = top_q - spm_pkg::OFF_W'(q_item.size)
		- spm_pkg::OFF_W'(spm_pkg::PREFIX_BYTES);
	assign baddr   = s_rd.off + spm_pkg::OFF_W'(spm_pkg::PREFIX_BYTES)
		+ spm_pkg::OFF_W'(it_q.byte_index);
	assign taddr   = toff_q + spm_pkg::OFF_W'(spm_pkg::PREFIX_BYTES)
		+ spm_pkg::OFF_W'(it_q.byte_index);

	always_comb begin
		case (k_q)
			2'd0:    pbyte = pval_q[7:0];
			2'd1:    pbyte = 8'(pval_q[spm_pkg::LEN_W-1:8]);
			default: pbyte = 8'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		it_d    = it_q;
		cnt_d   = cnt_q;
		top_d   = top_q;
		toff_d  = toff_q;
		tslot_d = tslot_q;
		tv_d    = tv_q;
		scan_d  = scan_q;
		paddr_d = paddr_q;
		pval_d  = pval_q;
		k_d     = k_q;
		ov_d    = ov_q && !out_ready;
		st_d    = st_q;
		sn_d    = sn_q;
		len_d   = len_q;
		rd_d    = rd_q;
		q_pop   = 1'b0;
		s_we    = 1'b0;
		s_addr  = q_item.slot;
		s_wd    = s_rd;
		p_we    = 1'b0;
		p_addr  = spm_pkg::PAGE_AW'(paddr_q);
		p_wd    = pbyte;

		unique case (state_q)
			spm_pkg::S_IDLE: begin
				if (q_valid && !ov_q) begin
					q_pop = 1'b1;
					it_d  = q_item;
					st_d  = spm_pkg::ST_OK;
					sn_d  = '0;
					len_d = '0;
					rd_d  = '0;
					unique case (q_item.op)
						spm_pkg::OP_INIT: begin
							cnt_d = '0;
							top_d = spm_pkg::TOP_INIT;
							tv_d  = 1'b0;
							ov_d  = 1'b1;
						end
						spm_pkg::OP_INSERT: begin
							if (cnt_q >= spm_pkg::CNT_W'(spm_pkg::MAX_SLOTS) || gap < need) begin
								st_d = spm_pkg::ST_NOSPACE;
								ov_d = 1'b1;
							end else begin
								s_we    = 1'b1;
								s_addr  = spm_pkg::SLOT_AW'(cnt_q);
								s_wd    = '{live: 1'b1, off: newtop, len: q_item.size};
								top_d   = newtop;
								toff_d  = newtop;
								tslot_d = spm_pkg::SLOT_AW'(cnt_q);
								tv_d    = 1'b1;
								sn_d    = spm_pkg::SLOT_AW'(cnt_q);
								len_d   = q_item.size;
								cnt_d   = cnt_q + 1'b1;
								paddr_d = newtop;
								pval_d  = q_item.size;
								k_d     = '0;
								state_d = spm_pkg::S_PFX;
							end
						end
						spm_pkg::OP_UPDATE, spm_pkg::OP_RBYTE, spm_pkg::OP_DELETE: begin
							sn_d = q_item.slot;
							if (spm_pkg::CNT_W'(q_item.slot) >= cnt_q) begin
								st_d = spm_pkg::ST_BEYOND;
								ov_d = 1'b1;
							end else begin
								state_d = spm_pkg::S_RD;
							end
						end
						spm_pkg::OP_WBYTE: begin
							if (!tv_q) begin
								st_d = spm_pkg::ST_NONE;
								ov_d = 1'b1;
							end else begin
								s_addr  = tslot_q;
								state_d = spm_pkg::S_RD;
							end
						end
						spm_pkg::OP_NEXT: begin
							if (spm_pkg::CNT_W'(q_item.slot) >= cnt_q) begin
								st_d = spm_pkg::ST_NONE;
								ov_d = 1'b1;
							end else begin
								scan_d  = q_item.slot;
								state_d = spm_pkg::S_SCAN;
							end
						end
						default: ov_d = 1'b1;
					endcase
				end
			end
			spm_pkg::S_RD: begin
				state_d = spm_pkg::S_IDLE;
				ov_d    = 1'b1;
				s_addr  = it_q.slot;
				unique case (it_q.op)
					spm_pkg::OP_UPDATE: begin
						if (!s_rd.live) begin
							st_d = spm_pkg::ST_DELETED;
						end else if (it_q.size > s_rd.len) begin
							st_d  = spm_pkg::ST_TOOBIG;
							len_d = s_rd.len;
						end else begin
							s_we    = 1'b1;
							s_wd    = '{live: 1'b1, off: s_rd.off, len: it_q.size};
							toff_d  = s_rd.off;
							tslot_d = it_q.slot;
							tv_d    = 1'b1;
							len_d   = it_q.size;
							paddr_d = s_rd.off;
							pval_d  = it_q.size;
							k_d     = '0;
							ov_d    = 1'b0;
							state_d = spm_pkg::S_PFX;
						end
					end
					spm_pkg::OP_RBYTE: begin
						if (!s_rd.live) begin
							st_d = spm_pkg::ST_DELETED;
						end else if (it_q.byte_index >= s_rd.len) begin
							st_d = spm_pkg::ST_RANGE;
						end else begin
							len_d   = s_rd.len;
							p_addr  = spm_pkg::PAGE_AW'(baddr);
							ov_d    = 1'b0;
							state_d = spm_pkg::S_BRD;
						end
					end
					spm_pkg::OP_DELETE: begin
						if (!s_rd.live) begin
							st_d = spm_pkg::ST_DELETED;
						end else begin
							s_we  = 1'b1;
							s_wd  = '{live: 1'b0, off: s_rd.off, len: s_rd.len};
							len_d = s_rd.len;
						end
					end
					default: begin
						// write into the current target record
						sn_d = tslot_q;
						if (!s_rd.live) begin
							st_d = spm_pkg::ST_DELETED;
						end else if (it_q.byte_index >= s_rd.len) begin
							st_d = spm_pkg::ST_RANGE;
						end else begin
							len_d  = s_rd.len;
							p_we   = 1'b1;
							p_addr = spm_pkg::PAGE_AW'(taddr);
							p_wd   = it_q.data_byte;
						end
					end
				endcase
			end
			spm_pkg::S_BRD: begin
				rd_d    = p_rd;
				ov_d    = 1'b1;
				state_d = spm_pkg::S_IDLE;
			end
			spm_pkg::S_SCAN: begin
				s_addr = scan_q;
				if (s_rd.live) begin
					sn_d    = scan_q;
					len_d   = s_rd.len;
					ov_d    = 1'b1;
					state_d = spm_pkg::S_IDLE;
				end else if (spm_pkg::CNT_W'(scan_q) + 1'b1 >= cnt_q) begin
					st_d    = spm_pkg::ST_NONE;
					ov_d    = 1'b1;
					state_d = spm_pkg::S_IDLE;
				end else begin
					scan_d = scan_q + 1'b1;
					s_addr = scan_q + 1'b1;
				end
			end
			spm_pkg::S_PFX: begin
				// write the length prefix, one byte a cycle
				p_we   = 1'b1;
				p_addr = spm_pkg::PAGE_AW'(paddr_q + spm_pkg::OFF_W'(k_q));
				k_d    = k_q + 1'b1;
				if (k_q == 2'd3) begin
					ov_d    = 1'b1;
					state_d = spm_pkg::S_IDLE;
				end
			end
			default: state_d = spm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::S_IDLE;
			cnt_q   <= '0;
			top_q   <= spm_pkg::TOP_INIT;
			toff_q  <= '0;
			tslot_q <= '0;
			tv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			top_q   <= top_d;
			toff_q  <= toff_d;
			tslot_q <= tslot_d;
			tv_q    <= tv_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		it_q    <= it_d;
		scan_q  <= scan_d;
		paddr_q <= paddr_d;
		pval_q  <= pval_d;
		k_q     <= k_d;
		st_q    <= st_d;
		sn_q    <= sn_d;
		len_q   <= len_d;
		rd_q    <= rd_d;
	end

	spm_ram #(.WIDTH($bits(spm_pkg::slot_ent_t)), .DEPTH(spm_pkg::MAX_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.addr  (s_addr),
		.wdata (s_wd),
		.rdata (s_rd)
	);

	spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_page_ram (
		.clk   (clk),
		.we    (p_we),
		.addr  (p_addr),
		.wdata (p_wd),
		.rdata (p_rd)
	);

	assign out_valid   = ov_q;
	assign status      = st_q;
	assign slot_number = sn_q;
	assign length      = len_q;
	assign read_data   = rd_q;
	assign free_bytes  = gap;

	ap_dir_fits: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= dir_end) else $error("slot directory overran record area");
	ap_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spm_pkg::CNT_W'(spm_pkg::MAX_SLOTS)) else $error("slot count overflow");
	ap_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == spm_pkg::S_IDLE && !ov_q)) else $error("pop while busy");
	ap_page_we: assert property (@(posedge clk) disable iff (!arst_n)
		p_we |-> (state_q == spm_pkg::S_PFX || state_q == spm_pkg::S_RD))
		else $error("stray page write");

endmodule

@@ src/slotted_page_manager_unit.sv @@
// Slotted page manager: keeps one 4096-byte page as a slotted page, with the
// slot directory growing up from a 16-byte header and length-prefixed records
// growing down from a 4-byte reserved tail at the page end. Each input beat
// carries one command (init, insert, update, write_byte, read_byte, delete,
// next_live) and yields exactly one result beat. A two-entry command queue
// decouples the input from the executing back end, so commands are taken while
// a result waits. Init, mode 7 and idle-state rejects answer directly; delete,
// write_byte and later rejects follow the slot read; good read_byte then reads
// the page; insert and good update write four prefix bytes, the update after
// the slot read; next_live scans slots in turn. The next command starts once
// the previous result is taken. page_id is written over the cfg port; the user
// must write it only while the block is idle; the block does not enforce it.
module slotted_page_manager_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  mode,
	input  logic [spm_pkg::SLOT_AW-1:0] slot,
	input  logic [spm_pkg::LEN_W-1:0]   size,
	input  logic [spm_pkg::IDX_W-1:0]   byte_index,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [spm_pkg::SLOT_AW-1:0] slot_number,
	output logic [spm_pkg::LEN_W-1:0]   length,
	output logic [7:0]                  read_data,
	output logic [31:0]                 page_number,
	output logic [spm_pkg::OFF_W-1:0]   free_bytes
);

	logic           q_valid, q_pop;
	spm_pkg::item_t q_item;
	logic [31:0]    page_id_q;

	// accept every config beat; hold the page id
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_id_q <= '0;
		end else if (cfg_valid) begin
			page_id_q <= cfg_data;
		end
	end
	assign page_number = page_id_q;

	spm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.slot       (slot),
		.size       (size),
		.byte_index (byte_index),
		.data_byte  (data_byte),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	spm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.slot_number (slot_number),
		.length      (length),
		.read_data   (read_data),
		.free_bytes  (free_bytes)
	);

endmodule

@@ test/slotted_page_manager_unit_tb.sv @@
`timescale 1ns / 1ps

module slotted_page_manager_unit_tb;

	// One command beat and one result beat, field for field as on the ports.
	typedef struct {
		spm_pkg::op_t                op;
		logic [spm_pkg::SLOT_AW-1:0] slot;
		logic [spm_pkg::LEN_W-1:0]   size;
		logic [spm_pkg::IDX_W-1:0]   byte_index;
		logic [7:0]                  data_byte;
	} cmd_t;

	typedef struct {
		spm_pkg::status_t            status;
		logic [spm_pkg::SLOT_AW-1:0] slot_number;
		logic [spm_pkg::LEN_W-1:0]   length;
		logic [7:0]                  read_data;
		logic [31:0]                 page_number;
		logic [spm_pkg::OFF_W-1:0]   free_bytes;
	} rec_res_t;

	// Directed row: the command, and where typed_res is set, the status, slot
	// and length that can be read straight off the page rules.
	typedef struct {
		cmd_t                        cmd;
		bit                          typed_res;
		spm_pkg::status_t            status;
		logic [spm_pkg::SLOT_AW-1:0] slot_number;
		logic [spm_pkg::LEN_W-1:0]   length;
	} row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [31:0]                 cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [2:0]                  mode = '0;
	logic [spm_pkg::SLOT_AW-1:0] slot = '0;
	logic [spm_pkg::LEN_W-1:0]   size = '0;
	logic [spm_pkg::IDX_W-1:0]   byte_index = '0;
	logic [7:0]                  data_byte = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [2:0]                  status;
	logic [spm_pkg::SLOT_AW-1:0] slot_number;
	logic [spm_pkg::LEN_W-1:0]   length;
	logic [7:0]                  read_data;
	logic [31:0]                 page_number;
	logic [spm_pkg::OFF_W-1:0]   free_bytes;

	slotted_page_manager_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .slot(slot), .size(size), .byte_index(byte_index),
		.data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot_number(slot_number), .length(length),
		.read_data(read_data), .page_number(page_number), .free_bytes(free_bytes)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Shadow copy of the page: bytes, directory, counters and write target.
	logic [7:0]        pg_mem [spm_pkg::PAGE_BYTES];
	bit                pg_written [spm_pkg::PAGE_BYTES];
	int unsigned       dir_off [spm_pkg::MAX_SLOTS];
	bit                dir_live [spm_pkg::MAX_SLOTS];
	int unsigned       dir_len [spm_pkg::MAX_SLOTS];
	int unsigned       live_count;
	int unsigned       rec_top;
	int unsigned       tgt_off;
	int unsigned       tgt_slot;
	bit                tgt_ok;
	logic [31:0]       page_tag;

	rec_res_t          pending_res[$];
	int                mismatches;
	int                send_gap_pct;
	int                recv_stall_pct;

	function automatic int unsigned page_gap();
		int unsigned dir_end;
		dir_end = 32'(spm_pkg::HEADER_BYTES) + live_count * 32'(spm_pkg::SLOT_BYTES);
		return (rec_top > dir_end) ? rec_top - dir_end : 0;
	endfunction

	function automatic void store_byte(int unsigned addr, logic [7:0] v);
		if (addr < 32'(spm_pkg::PAGE_BYTES)) begin
			pg_mem[addr] = v;
			pg_written[addr] = 1'b1;
		end
	endfunction

	function automatic void store_len_prefix(int unsigned off, int unsigned len);
		for (int unsigned k = 0; k < 32'(spm_pkg::PREFIX_BYTES); k++)
			store_byte(off + k, 8'((len >> (8 * k)) & 32'hFF));
	endfunction

	// Apply one command to the shadow page and return the result it yields.
	function automatic rec_res_t apply_page_cmd(cmd_t c);
		rec_res_t r;
		int unsigned total;
		int unsigned s;
		r.status = spm_pkg::ST_OK;
		r.slot_number = '0;
		r.length = '0;
		r.read_data = '0;
		s = 32'(c.slot);
		case (c.op)
			spm_pkg::OP_INIT: begin
				live_count = 0;
				rec_top = 32'(spm_pkg::PAGE_BYTES - spm_pkg::RSVD_BYTES);
				tgt_ok = 1'b0;
			end
			spm_pkg::OP_INSERT: begin
				total = 32'(spm_pkg::PREFIX_BYTES) + 32'(c.size);
				if (live_count >= 32'(spm_pkg::MAX_SLOTS) ||
					page_gap() < total + 32'(spm_pkg::SLOT_BYTES)) begin
					r.status = spm_pkg::ST_NOSPACE;
				end else begin
					rec_top -= total;
					store_len_prefix(rec_top, 32'(c.size));
					dir_off[live_count] = rec_top;
					dir_live[live_count] = 1'b1;
					dir_len[live_count] = 32'(c.size);
					tgt_off = rec_top;
					tgt_slot = live_count;
					tgt_ok = 1'b1;
					r.slot_number = spm_pkg::SLOT_AW'(live_count);
					r.length = c.size;
					live_count++;
				end
			end
			spm_pkg::OP_UPDATE, spm_pkg::OP_RBYTE, spm_pkg::OP_DELETE: begin
				r.slot_number = c.slot;
				if (s >= live_count) r.status = spm_pkg::ST_BEYOND;
				else if (!dir_live[s]) r.status = spm_pkg::ST_DELETED;
				else begin
					r.length = spm_pkg::LEN_W'(dir_len[s]);
					if (c.op == spm_pkg::OP_UPDATE) begin
						if (32'(c.size) > dir_len[s]) r.status = spm_pkg::ST_TOOBIG;
						else begin
							dir_len[s] = 32'(c.size);
							store_len_prefix(dir_off[s], 32'(c.size));
							tgt_off = dir_off[s];
							tgt_slot = s;
							tgt_ok = 1'b1;
							r.length = c.size;
						end
					end else if (c.op == spm_pkg::OP_RBYTE) begin
						if (32'(c.byte_index) >= dir_len[s]) begin
							r.status = spm_pkg::ST_RANGE;
							r.length = '0;
						end else begin
							r.read_data = pg_mem[dir_off[s] + 32'(spm_pkg::PREFIX_BYTES)
								+ 32'(c.byte_index)];
						end
					end else begin
						dir_live[s] = 1'b0;
					end
				end
			end
			spm_pkg::OP_WBYTE: begin
				if (!tgt_ok) r.status = spm_pkg::ST_NONE;
				else begin
					r.slot_number = spm_pkg::SLOT_AW'(tgt_slot);
					if (!dir_live[tgt_slot]) r.status = spm_pkg::ST_DELETED;
					else if (32'(c.byte_index) >= dir_len[tgt_slot]) r.status = spm_pkg::ST_RANGE;
					else begin
						r.length = spm_pkg::LEN_W'(dir_len[tgt_slot]);
						store_byte(tgt_off + 32'(spm_pkg::PREFIX_BYTES) + 32'(c.byte_index),
							c.data_byte);
					end
				end
			end
			spm_pkg::OP_NEXT: begin
				r.status = spm_pkg::ST_NONE;
				for (int unsigned i = s; i < live_count; i++) begin
					if (dir_live[i]) begin
						r.status = spm_pkg::ST_OK;
						r.slot_number = spm_pkg::SLOT_AW'(i);
						r.length = spm_pkg::LEN_W'(dir_len[i]);
						break;
					end
				end
			end
			default: ;
		endcase
		r.page_number = page_tag;
		r.free_bytes = spm_pkg::OFF_W'(page_gap());
		return r;
	endfunction

	// Receiver: stall at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Result beats: sample at the falling edge, the rising edge that follows takes them.
	always @(negedge clk) begin
		rec_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d slot %0d", status, slot_number);
			end else begin
				e = pending_res.pop_front();
				if (status !== e.status || slot_number !== e.slot_number ||
					length !== e.length || read_data !== e.read_data ||
					page_number !== e.page_number || free_bytes !== e.free_bytes) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: exp st %0d sl %0d len %0d rd %h pg %h fr %0d",
							" / got st %0d sl %0d len %0d rd %h pg %h fr %0d"},
							e.status, e.slot_number, e.length, e.read_data, e.page_number,
							e.free_bytes, status, slot_number, length, read_data,
							page_number, free_bytes);
				end
			end
		end
	end

	// Drive one command beat; return right after the edge that takes it.
	task automatic send_cmd(cmd_t c, bit typed, rec_res_t typed_res);
		rec_res_t e;
		bit took;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		e = apply_page_cmd(c);
		if (typed) begin
			e.status = typed_res.status;
			e.slot_number = typed_res.slot_number;
			e.length = typed_res.length;
		end
		pending_res.push_back(e);
		in_valid <= 1'b1;
		mode <= c.op;
		slot <= c.slot;
		size <= c.size;
		byte_index <= c.byte_index;
		data_byte <= c.data_byte;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Hold the sender until every pending result has drained.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_page_tag(logic [31:0] v);
		bit took;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		page_tag = v;
	endtask

	function automatic logic [spm_pkg::LEN_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return spm_pkg::LEN_W'($urandom_range(0, 24));
		if (r < 95) return spm_pkg::LEN_W'($urandom_range(0, 300));
		return spm_pkg::LEN_W'($urandom());
	endfunction

	// Random command: mostly well-formed traffic around live records.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int r;
		int unsigned a;
		c.op = spm_pkg::OP_NOP;
		c.slot = spm_pkg::SLOT_AW'($urandom());
		c.size = spm_pkg::LEN_W'($urandom());
		c.byte_index = spm_pkg::IDX_W'($urandom());
		c.data_byte = 8'($urandom());
		r = $urandom_range(0, 99);
		if (r < 3 || (page_gap() < 64 && $urandom_range(0, 3) == 0)) c.op = spm_pkg::OP_INIT;
		else if (r < 25) begin
			c.op = spm_pkg::OP_INSERT;
			c.size = pick_size();
		end else if (r < 50) begin
			c.op = spm_pkg::OP_WBYTE;
			if (tgt_ok && dir_len[tgt_slot] != 0 && $urandom_range(0, 9) != 0)
				c.byte_index = spm_pkg::IDX_W'($urandom_range(0, dir_len[tgt_slot] - 1));
		end else if (r < 96) begin
			if (r < 70) c.op = spm_pkg::OP_RBYTE;
			else if (r < 78) c.op = spm_pkg::OP_UPDATE;
			else if (r < 86) c.op = spm_pkg::OP_DELETE;
			else c.op = spm_pkg::OP_NEXT;
			if (live_count != 0 && $urandom_range(0, 9) != 0)
				c.slot = spm_pkg::SLOT_AW'($urandom_range(0, live_count - 1));
			if (live_count != 0 && dir_len[c.slot] != 0 && $urandom_range(0, 9) != 0) begin
				c.byte_index = spm_pkg::IDX_W'($urandom_range(0, dir_len[c.slot] - 1));
				c.size = spm_pkg::LEN_W'($urandom_range(0, dir_len[c.slot] + 2));
			end
		end
		// Never read a payload byte that was not written since reset: write it instead.
		if (c.op == spm_pkg::OP_RBYTE && 32'(c.slot) < live_count && dir_live[c.slot] &&
			32'(c.byte_index) < dir_len[c.slot]) begin
			a = dir_off[c.slot] + 32'(spm_pkg::PREFIX_BYTES) + 32'(c.byte_index);
			if (!pg_written[a]) c.op = spm_pkg::OP_WBYTE;
		end
		return c;
	endfunction

	function automatic row_t mk(spm_pkg::op_t op, int s, int sz, int bi, int db,
		bit typed = 1'b0, spm_pkg::status_t st = spm_pkg::ST_OK, int sn = 0, int ln = 0);
		row_t w;
		w.cmd.op = op;
		w.cmd.slot = spm_pkg::SLOT_AW'(s);
		w.cmd.size = spm_pkg::LEN_W'(sz);
		w.cmd.byte_index = spm_pkg::IDX_W'(bi);
		w.cmd.data_byte = 8'(db);
		w.typed_res = typed;
		w.status = st;
		w.slot_number = spm_pkg::SLOT_AW'(sn);
		w.length = spm_pkg::LEN_W'(ln);
		return w;
	endfunction

	row_t directed[$];

	initial begin
		rec_res_t tr;
		int sender_pct[4];
		int stall_pct[4];
		logic [31:0] tags[4];

		sender_pct = '{0, 69, 0, 6};
		stall_pct = '{0, 0, 69, 6};
		mismatches = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		page_tag = '0;
		live_count = 0;
		rec_top = 32'(spm_pkg::PAGE_BYTES - spm_pkg::RSVD_BYTES);
		tgt_off = 0;
		tgt_slot = 0;
		tgt_ok = 1'b0;
		foreach (pg_mem[i]) begin
			pg_mem[i] = '0;
			pg_written[i] = 1'b0;
		end
		foreach (dir_live[i]) begin
			dir_live[i] = 1'b0;
			dir_off[i] = 0;
			dir_len[i] = 0;
		end
		tags = '{32'hFFFF_FFFF, $urandom(), 32'h0, $urandom()};

		// Empty page first, then a record life cycle, then a page filled to the byte.
		directed = '{
			mk(spm_pkg::OP_NEXT, 0, 0, 0, 0, 1, spm_pkg::ST_NONE, 0, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 0, 8'h5A, 1, spm_pkg::ST_NONE, 0, 0),
			mk(spm_pkg::OP_RBYTE, 0, 0, 0, 0, 1, spm_pkg::ST_BEYOND, 0, 0),
			mk(spm_pkg::OP_INSERT, 0, 4095, 0, 0, 1, spm_pkg::ST_NOSPACE, 0, 0),
			mk(spm_pkg::OP_INSERT, 0, 0, 0, 0, 1, spm_pkg::ST_OK, 0, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 0, 8'h11, 1, spm_pkg::ST_RANGE, 0, 0),
			mk(spm_pkg::OP_INSERT, 0, 4, 0, 0, 1, spm_pkg::ST_OK, 1, 4),
			mk(spm_pkg::OP_WBYTE, 0, 0, 3, 8'hFF, 1, spm_pkg::ST_OK, 1, 4),
			mk(spm_pkg::OP_WBYTE, 0, 0, 0, 8'h00, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 1, 8'hA5, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 2, 8'h3C, 0),
			mk(spm_pkg::OP_RBYTE, 1, 0, 3, 0, 0),
			mk(spm_pkg::OP_RBYTE, 1, 0, 4, 0, 1, spm_pkg::ST_RANGE, 1, 0),
			mk(spm_pkg::OP_UPDATE, 1, 5, 0, 0, 1, spm_pkg::ST_TOOBIG, 1, 4),
			mk(spm_pkg::OP_UPDATE, 1, 2, 0, 0, 0),
			mk(spm_pkg::OP_RBYTE, 1, 0, 1, 0, 0),
			mk(spm_pkg::OP_DELETE, 0, 0, 0, 0, 1, spm_pkg::ST_OK, 0, 0),
			mk(spm_pkg::OP_RBYTE, 0, 0, 0, 0, 1, spm_pkg::ST_DELETED, 0, 0),
			mk(spm_pkg::OP_NEXT, 0, 0, 0, 0, 0),
			mk(spm_pkg::OP_DELETE, 1, 0, 0, 0, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 0, 8'h77, 1, spm_pkg::ST_DELETED, 1, 0),
			mk(spm_pkg::OP_UPDATE, 511, 4095, 4095, 0, 1, spm_pkg::ST_BEYOND, 511, 0),
			mk(spm_pkg::OP_NEXT, 511, 0, 0, 0, 1, spm_pkg::ST_NONE, 0, 0),
			mk(spm_pkg::OP_NOP, 511, 4095, 4095, 8'hFF, 1, spm_pkg::ST_OK, 0, 0),
			mk(spm_pkg::OP_INIT, 0, 0, 0, 0, 1, spm_pkg::ST_OK, 0, 0),
			mk(spm_pkg::OP_INSERT, 0, 4068, 0, 0, 1, spm_pkg::ST_OK, 0, 4068),
			mk(spm_pkg::OP_INSERT, 0, 0, 0, 0, 1, spm_pkg::ST_NOSPACE, 0, 0),
			mk(spm_pkg::OP_WBYTE, 0, 0, 4067, 8'hAA, 0),
			mk(spm_pkg::OP_RBYTE, 0, 0, 4067, 0, 0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at full rate under the reset page_id.
		foreach (directed[i]) begin
			tr.status = directed[i].status;
			tr.slot_number = directed[i].slot_number;
			tr.length = directed[i].length;
			send_cmd(directed[i].cmd, directed[i].typed_res, tr);
		end

		for (int ph = 0; ph < 4; ph++) begin
			write_page_tag(tags[ph]);
			send_gap_pct = sender_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int n = 0; n < 232; n++) begin
				if (n == 116) drain_results();
				send_cmd(random_cmd(), 1'b0, tr);
			end
		end

		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
src/spm_pkg.sv
src/spm_ram.sv
src/spm_front.sv
src/spm_back.sv
src/slotted_page_manager_unit.sv
test/slotted_page_manager_unit_tb.sv
